[rtl/hex_object_line_loader_assert.svh]
// ----------------------------------------------------------------------------
// hex object line loader assertion macros
// property forms for the concurrent checks in the loader controller
// ----------------------------------------------------------------------------
`ifndef HEX_OBJECT_LINE_LOADER_ASSERT_SVH
`define HEX_OBJECT_LINE_LOADER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HOL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("loader check failed");

// next-cycle implication, checked outside reset
`define HOL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("loader check failed");

`endif

[rtl/hol_pkg.sv]
// ----------------------------------------------------------------------------
// hol_pkg
// types, constants and helpers shared by the object line loader modules
// ----------------------------------------------------------------------------
package hol_pkg;

   localparam int unsigned MEM_BYTES = 4096;
   localparam int unsigned BUF_DEPTH = 10;
   localparam int unsigned ADDR_W    = 12;
   localparam int unsigned DATA_W    = 8;
   localparam int unsigned COL_W     = 5;
   localparam int unsigned CNT_W     = 4;
   localparam int unsigned IDX_W     = $clog2(BUF_DEPTH);

   localparam logic [COL_W-1:0] COL_XCHAR = 5'd1;
   localparam logic [COL_W-1:0] COL_ADDR_END = 5'd4;
   localparam logic [COL_W-1:0] COL_COLON = 5'd5;
   localparam logic [COL_W-1:0] COL_SPACE = 5'd6;
   localparam logic [COL_W-1:0] COL_DATA  = 5'd7;
   localparam logic [COL_W-1:0] COL_BAR   = 5'd28;
   localparam logic [COL_W-1:0] COL_PAST  = 5'd29;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BAR   = 8'h7C;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   // controller to datapath
   typedef struct packed {
      logic             take_char;
      logic             load_byte;
      logic             load_status;
      logic             status_reject;
      logic             clear_line;
      logic [IDX_W-1:0] byte_index;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic             reject;
      logic             emit;
      logic [CNT_W-1:0] byte_count;
   } status_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

[rtl/hol_datapath.sv]
// ----------------------------------------------------------------------------
// hol_datapath
// line parser, byte buffer, load bookkeeping and result register
// ----------------------------------------------------------------------------
module hol_datapath #(
   parameter int unsigned MEM_BYTES = hol_pkg::MEM_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                char_code,
   input  hol_pkg::cmd_type          cmd,
   output hol_pkg::status_type       status,
   output hol_pkg::kind_type         out_kind,
   output logic [hol_pkg::ADDR_W-1:0] out_address,
   output logic [hol_pkg::DATA_W-1:0] out_data,
   output logic                      out_last
);

   localparam logic [hol_pkg::ADDR_W:0] MEM_LIMIT = (hol_pkg::ADDR_W+1)'(MEM_BYTES);

   logic [hol_pkg::COL_W-1:0]  column_ff, column_in;
   logic [hol_pkg::ADDR_W-1:0] line_address_ff, line_address_in;
   logic [3:0]                 high_nibble_ff, high_nibble_in;
   logic [hol_pkg::CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic                       in_data_run_ff, in_data_run_in;
   logic                       all_blank_ff, all_blank_in;
   logic                       line_bad_ff, line_bad_in;
   logic [hol_pkg::ADDR_W-1:0] last_address_ff, last_address_in;
   logic                       any_loaded_ff, any_loaded_in;

   logic [hol_pkg::DATA_W-1:0] byte_buffer_ff [hol_pkg::BUF_DEPTH];

   hol_pkg::kind_type          kind_ff;
   logic [hol_pkg::ADDR_W-1:0] address_ff;
   logic [hol_pkg::DATA_W-1:0] data_ff;
   logic                       last_ff;

   logic [4:0]                 hex;
   logic                       is_hex;
   logic [hol_pkg::COL_W-1:0]  offset;
   logic                       buf_write;
   logic [hol_pkg::ADDR_W-1:0] write_address;
   logic [hol_pkg::ADDR_W:0]   line_end_sum;
   logic                       range_bad;
   logic                       order_bad;

   assign hex    = hol_pkg::hex_decode(char_code);
   assign is_hex = hex[4];
   assign offset = column_ff - hol_pkg::COL_DATA;

   always_comb begin
      column_in       = column_ff;
      line_address_in = line_address_ff;
      high_nibble_in  = high_nibble_ff;
      byte_count_in   = byte_count_ff;
      in_data_run_in  = in_data_run_ff;
      all_blank_in    = all_blank_ff;
      line_bad_in     = line_bad_ff;
      buf_write       = 1'b0;
      if (cmd.clear_line) begin
         column_in       = '0;
         line_address_in = '0;
         high_nibble_in  = '0;
         byte_count_in   = '0;
         in_data_run_in  = 1'b0;
         all_blank_in    = 1'b1;
         line_bad_in     = 1'b0;
      end else if (cmd.take_char && column_ff < hol_pkg::COL_PAST) begin
         column_in = column_ff + 1'b1;
         if (column_ff < hol_pkg::COL_BAR && char_code != hol_pkg::CH_SPACE) begin
            all_blank_in = 1'b0;
         end
         if (column_ff == '0) begin
            if (char_code != hol_pkg::CH_ZERO) line_bad_in = 1'b1;
         end else if (column_ff == hol_pkg::COL_XCHAR) begin
            if (char_code != hol_pkg::CH_X) line_bad_in = 1'b1;
         end else if (column_ff <= hol_pkg::COL_ADDR_END) begin
            if (!is_hex) line_bad_in = 1'b1;
            else line_address_in = {line_address_ff[hol_pkg::ADDR_W-5:0], hex[3:0]};
         end else if (column_ff == hol_pkg::COL_COLON) begin
            if (char_code != hol_pkg::CH_COLON) line_bad_in = 1'b1;
         end else if (column_ff == hol_pkg::COL_SPACE) begin
            if (char_code != hol_pkg::CH_SPACE) line_bad_in = 1'b1;
            in_data_run_in = 1'b1;
         end else if (in_data_run_ff && is_hex && column_ff < hol_pkg::COL_BAR) begin
            if (!offset[0]) begin
               high_nibble_in = hex[3:0];
            end else if (byte_count_ff < hol_pkg::CNT_W'(hol_pkg::BUF_DEPTH)) begin
               buf_write     = 1'b1;
               byte_count_in = byte_count_ff + 1'b1;
            end
         end else begin
            // data run ends: a dangling high digit spoils the line
            if (in_data_run_ff) begin
               in_data_run_in = 1'b0;
               if (offset[0]) line_bad_in = 1'b1;
            end
            if (column_ff < hol_pkg::COL_BAR) begin
               if (char_code != hol_pkg::CH_SPACE) line_bad_in = 1'b1;
            end else if (char_code != hol_pkg::CH_BAR) begin
               line_bad_in  = 1'b1;
               all_blank_in = 1'b0;
            end
         end
      end
   end

   // line verdict, read by the controller when the line end is taken
   assign line_end_sum = {1'b0, line_address_ff} + (hol_pkg::ADDR_W+1)'(byte_count_ff);
   assign range_bad    = line_end_sum > MEM_LIMIT;
   assign order_bad    = any_loaded_ff && (line_address_ff <= last_address_ff);

   always_comb begin
      status.reject     = (column_ff < hol_pkg::COL_PAST) ||
                          (!all_blank_ff && (line_bad_ff || order_bad || range_bad));
      status.emit       = !status.reject && !all_blank_ff && (byte_count_ff != '0);
      status.byte_count = byte_count_ff;
   end

   assign write_address = line_address_ff + hol_pkg::ADDR_W'(cmd.byte_index);

   always_comb begin
      last_address_in = last_address_ff;
      any_loaded_in   = any_loaded_ff;
      if (cmd.load_byte) begin
         last_address_in = write_address;
         any_loaded_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff       <= '0;
         line_address_ff <= '0;
         high_nibble_ff  <= '0;
         byte_count_ff   <= '0;
         in_data_run_ff  <= 1'b0;
         all_blank_ff    <= 1'b1;
         line_bad_ff     <= 1'b0;
         last_address_ff <= '0;
         any_loaded_ff   <= 1'b0;
      end else begin
         column_ff       <= column_in;
         line_address_ff <= line_address_in;
         high_nibble_ff  <= high_nibble_in;
         byte_count_ff   <= byte_count_in;
         in_data_run_ff  <= in_data_run_in;
         all_blank_ff    <= all_blank_in;
         line_bad_ff     <= line_bad_in;
         last_address_ff <= last_address_in;
         any_loaded_ff   <= any_loaded_in;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_write) begin
         byte_buffer_ff[byte_count_ff] <= {high_nibble_ff, hex[3:0]};
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         kind_ff    <= hol_pkg::KIND_WRITE;
         address_ff <= write_address;
         data_ff    <= byte_buffer_ff[cmd.byte_index];
         last_ff    <= 1'b0;
      end else if (cmd.load_status) begin
         kind_ff    <= cmd.status_reject ? hol_pkg::KIND_REJECT : hol_pkg::KIND_ACCEPT;
         address_ff <= '0;
         data_ff    <= '0;
         last_ff    <= 1'b1;
      end
   end

   assign out_kind    = kind_ff;
   assign out_address = address_ff;
   assign out_data    = data_ff;
   assign out_last    = last_ff;

endmodule

[rtl/hol_ctrl.sv]
// ----------------------------------------------------------------------------
// hol_ctrl
// sequencer: character intake, byte drain, line status and halt
// ----------------------------------------------------------------------------
`include "hex_object_line_loader_assert.svh"

module hol_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  hol_pkg::status_type status,
   output hol_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_RUN    = 4'b0001,
      ST_DRAIN  = 4'b0010,
      ST_STATUS = 4'b0100,
      ST_HALT   = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [hol_pkg::IDX_W-1:0] byte_index_ff, byte_index_in;
   logic                      reject_ff, reject_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_free;
   logic                      req_accept;
   logic [hol_pkg::CNT_W-1:0] drain_last;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_RUN) || (state_ff == ST_HALT);
   assign req_accept = req_tvalid && req_tready;
   assign drain_last = status.byte_count - 1'b1;

   always_comb begin
      state_in          = state_ff;
      byte_index_in     = byte_index_ff;
      reject_in         = reject_ff;
      cmd.take_char     = 1'b0;
      cmd.load_byte     = 1'b0;
      cmd.load_status   = 1'b0;
      cmd.status_reject = reject_ff;
      cmd.clear_line    = 1'b0;
      cmd.byte_index    = byte_index_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (req_accept) begin
               if (!req_tlast) begin
                  cmd.take_char = 1'b1;
               end else begin
                  reject_in     = status.reject;
                  byte_index_in = '0;
                  state_in      = status.emit ? ST_DRAIN : ST_STATUS;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               cmd.load_byte = 1'b1;
               byte_index_in = byte_index_ff + 1'b1;
               if (hol_pkg::CNT_W'(byte_index_ff) == drain_last) state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               cmd.load_status = 1'b1;
               cmd.clear_line  = 1'b1;
               state_in        = reject_ff ? ST_HALT : ST_RUN;
            end
         end
         ST_HALT: begin
            // items are taken and dropped until reset
         end
         default: begin
            state_in = ST_HALT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_byte || cmd.load_status) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         byte_index_ff <= '0;
         reject_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         byte_index_ff <= byte_index_in;
         reject_ff     <= reject_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `HOL_ASSERT_NOW(a_drain_in_range, clock, reset, state_ff == ST_DRAIN,
      hol_pkg::CNT_W'(byte_index_ff) < status.byte_count)
   `HOL_ASSERT_NEXT(a_reject_halts, clock, reset, cmd.load_status && reject_ff,
      state_ff == ST_HALT)
   `HOL_ASSERT_NEXT(a_halt_sticks, clock, reset, state_ff == ST_HALT,
      state_ff == ST_HALT && !cmd.load_byte && !cmd.load_status)
   `HOL_ASSERT_NEXT(a_line_end_leaves_run, clock, reset,
      state_ff == ST_RUN && req_accept && req_tlast, state_ff != ST_RUN)
   `HOL_ASSERT_NOW(a_no_load_over_stall, clock, reset,
      rsp_valid_ff && !rsp_tready, !cmd.load_byte && !cmd.load_status)

endmodule

[rtl/hex_object_line_loader.sv]
// ----------------------------------------------------------------------------
// hex_object_line_loader
// checks fixed-column object-file text lines and turns them into byte writes
// ----------------------------------------------------------------------------
// Characters are taken one per cycle; an item with tlast set ends the line and
// carries no character. After a line end the block stops taking input while
// it emits one byte write per buffered data byte, none for a rejected line,
// and then a line status, one result per cycle from a single result register
// while the result side does not stall, so after a line end the input is held
// off until the status is loaded. The next line's first character can follow
// in the cycle after the status is loaded. A rejected line halts the block: it
// keeps taking and dropping items with no results until reset.
module hex_object_line_loader #(
   parameter int unsigned MEM_BYTES = hol_pkg::MEM_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // line_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [11:0] address, [19:12] data, [23:20] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last
);

   hol_pkg::cmd_type           cmd;
   hol_pkg::status_type        status;
   hol_pkg::kind_type          out_kind;
   logic [hol_pkg::ADDR_W-1:0] out_address;
   logic [hol_pkg::DATA_W-1:0] out_data;
   logic                       out_last;

   hol_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hol_datapath #(
      .MEM_BYTES (MEM_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .char_code   (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .out_kind    (out_kind),
      .out_address (out_address),
      .out_data    (out_data),
      .out_last    (out_last)
   );

   assign rsp_tdata = {4'b0000, out_data, out_address};
   assign rsp_tuser = out_kind;
   assign rsp_tlast = out_last;

endmodule
